### sv/page_range_work_dispenser_assert.svh
// Assertion macros for the page range work dispenser.
// Included by the top level; no other dependencies.
`ifndef PAGE_RANGE_WORK_DISPENSER_ASSERT_SVH
`define PAGE_RANGE_WORK_DISPENSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PRWD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PRWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PRWD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define PRWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/prwd_pkg.sv
// Shared types and constants of the page range work dispenser.
// No dependencies.
package prwd_pkg;
  localparam int VW            = 34;  // internal block arithmetic width
  localparam int CW            = 21;  // unit size times node count
  localparam int UW            = 17;  // unit size register
  localparam int NCFGW         = 5;   // node count register
  localparam int PW            = 32;  // block numbers on the ports
  localparam int KEYW          = 16;
  localparam int CFG_IW        = 1;
  localparam int SMALL_DIV     = 16;
  localparam int DEF_MAX_TASKS = 4;
  localparam int DEF_MAX_NODES = 16;

  typedef logic signed [VW-1:0] val_t;

  typedef struct packed {
    val_t head_lo;
    val_t head_hi;
    val_t tail_lo;
    val_t tail_hi;
    val_t cursor;
  } node_ent_t;

  typedef enum logic [2:0] {
    ST_GRANT      = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_ROUND_DONE = 3'd2,
    ST_FULL       = 3'd3,
    ST_BEYOND     = 3'd4
  } status_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_NODE_COUNT = 1'b0,
    CFG_UNIT_SIZE  = 1'b1
  } cfg_idx_t;
endpackage

### sv/prwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prwd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### sv/prwd_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on prwd_pkg.
module prwd_rem
  import prwd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [VW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic          done,
  output logic [CW-1:0] rem
);
  localparam int CNTW = $clog2(VW);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [VW-1:0]   dvd_r;
  logic [CW-1:0]   dvs_r;
  logic [CW-1:0]   rem_r;
  logic [CW:0]     trial;
  logic [CW:0]     diff;

  // shift in the next dividend bit and try to subtract
  always_comb begin
    trial = {rem_r, dvd_r[VW-1]};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= diff[CW] ? trial[CW-1:0] : diff[CW-1:0];
        dvd_r <= {dvd_r[VW-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(VW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule

### sv/page_range_work_dispenser.sv
// Top level of the page range work dispenser: task table, sequencer, node RAM.
// Depends on prwd_pkg, prwd_ram, prwd_rem and the assertion macro header.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | operation, task, round, range, node
//   out_    | output    | out_valid / out_stall| status, first_block, last_block
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request at a time. A request on a known task runs through lookup, prepare,
// pick, RAM load, take and finish. A new task or a new round adds two remainder
// runs of the serial divider plus one node RAM write per node. Each backward skip
// step over the node RAM rereads an entry, and a jump adds two more remainder runs.
// Synchronous active-low reset empties the task table; the node RAM is not cleared.
// The result register lets a new request in while a result is stalled at out_.
`include "page_range_work_dispenser_assert.svh"
module page_range_work_dispenser
  import prwd_pkg::*;
#(
  parameter int MAX_TASKS = DEF_MAX_TASKS,
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [KEYW-1:0]   in_task_id,
  input  logic [31:0]       in_scan_round,
  input  logic              in_backward,
  input  logic              in_whole_relation,
  input  logic [PW-1:0]     in_scan_start,
  input  logic [PW-1:0]     in_scan_count,
  input  logic [PW-1:0]     in_page_count,
  input  logic [3:0]        in_node_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [PW-1:0]     out_first_block,
  output logic [PW-1:0]     out_last_block,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [UW-1:0]     cfg_data
);
  localparam int NSLOT = MAX_TASKS * MAX_NODES;
  localparam int TW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int AW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int NCW   = $clog2(MAX_NODES + 1);
  localparam int EW    = $bits(node_ent_t);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_LOOK  = 12'b0000_0000_0010,
    S_PREP  = 12'b0000_0000_0100,
    S_DGO   = 12'b0000_0000_1000,
    S_DWAIT = 12'b0000_0001_0000,
    S_SETUP = 12'b0000_0010_0000,
    S_PICK  = 12'b0000_0100_0000,
    S_LOAD  = 12'b0000_1000_0000,
    S_TAKE  = 12'b0001_0000_0000,
    S_SKRD  = 12'b0010_0000_0000,
    S_SKLD  = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [1:0] {
    DIV_LO  = 2'd0,
    DIV_HI  = 2'd1,
    DIV_SK1 = 2'd2,
    DIV_SK2 = 2'd3
  } div_sel_t;

  function automatic logic [AW-1:0] slot_addr(input logic [TW-1:0] t,
                                               input logic [NW-1:0] i);
    return AW'(int'(t) * MAX_NODES + int'(i));
  endfunction

  // control and configuration
  state_t            state_r;
  logic [NCFGW-1:0]  node_count_r;
  logic [UW-1:0]     unit_size_r;

  // task table
  logic [MAX_TASKS-1:0] slot_valid_r;
  logic [KEYW-1:0]      slot_key_r   [MAX_TASKS];
  logic [31:0]          slot_round_r [MAX_TASKS];
  logic                 slot_back_r  [MAX_TASKS];
  val_t                 slot_lo_r    [MAX_TASKS];
  val_t                 slot_hi_r    [MAX_TASKS];
  logic [NCW-1:0]       slot_nodes_r [MAX_TASKS];
  logic [UW-1:0]        slot_unit_r  [MAX_TASKS];

  // captured request
  logic            req_op_r;
  logic [KEYW-1:0] req_key_r;
  logic [31:0]     req_round_r;
  logic            req_back_r;
  logic            req_whole_r;
  logic [PW-1:0]   req_ss_r;
  logic [PW-1:0]   req_cnt_r;
  logic [PW-1:0]   req_pc_r;
  logic [3:0]      req_own_r;

  // working registers
  logic [TW-1:0]   t_r;
  logic [UW-1:0]   b_r;
  logic [NCW-1:0]  n_r;
  logic [CW-1:0]   c_r;
  val_t            lo_r;
  val_t            hi_r;
  logic            tback_r;
  logic            setup_r;
  logic            skip_r;
  logic            last_r;
  logic [NW-1:0]   s_r;
  logic [NW-1:0]   i_r;
  val_t            bi_r;
  val_t            hp_r;
  val_t            tp_r;
  div_sel_t        div_sel_r;
  logic [CW-1:0]   ra_r;
  val_t            d1_r;
  val_t            d2_r;
  node_ent_t       ent_r;
  logic [NSLOT-1:0] done_r;
  status_t         res_status_r;
  logic [PW-1:0]   res_st_r;
  logic [PW-1:0]   res_en_r;
  logic            out_valid_r;
  status_t         out_status_r;
  logic [PW-1:0]   out_st_r;
  logic [PW-1:0]   out_en_r;

  // common operands
  val_t bx, cx, pcx;
  assign bx  = val_t'(b_r);
  assign cx  = val_t'(c_r);
  assign pcx = val_t'(req_pc_r);

  // ---------------- task lookup ----------------
  logic            match_hit, free_hit;
  logic [TW-1:0]   match_idx, free_idx;
  logic [UW-1:0]   b_cur;
  logic [NCW-1:0]  n_cur;
  val_t            nlo, nhi, ssx, cntx;

  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    free_hit  = 1'b0;
    free_idx  = '0;
    for (int k = 0; k < MAX_TASKS; k++) begin
      if (!match_hit && slot_valid_r[k] && slot_key_r[k] == req_key_r) begin
        match_hit = 1'b1;
        match_idx = TW'(k);
      end
      if (!free_hit && !slot_valid_r[k]) begin
        free_hit = 1'b1;
        free_idx = TW'(k);
      end
    end
    b_cur = (unit_size_r == '0) ? UW'(1) : unit_size_r;
    n_cur = (int'(node_count_r) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(node_count_r);
    ssx   = val_t'(req_ss_r);
    cntx  = val_t'(req_cnt_r);
    // range of a new task
    if (req_whole_r) begin
      nlo = '0;
      nhi = pcx - 1;
    end else if (!req_back_r) begin
      nlo = ssx;
      nhi = ssx + cntx - 1;
      if (nhi >= pcx) nhi = pcx - 1;
    end else begin
      nhi = ssx;
      nlo = ssx - cntx + 1;
      if (nlo < 0) nlo = '0;
    end
  end

  // ---------------- per-node setup ----------------
  node_ent_t su_ent;
  logic      su_done;

  always_comb begin
    val_t tb, te, hb, he;
    tb = tp_r + bi_r;
    te = tb + bx - 1;
    hb = hp_r + bi_r;
    he = hb + bx - 1;
    su_done = 1'b0;
    if (tb > hi_r) begin
      tb = tb - cx;
      te = te - cx;
    end else if (te > hi_r) begin
      te = hi_r;
    end
    if (te < lo_r) su_done = 1'b1;
    else if (tb < lo_r) tb = lo_r;
    if (he < lo_r) begin
      hb = hb + cx;
      he = he + cx;
    end else if (hb < lo_r) begin
      hb = lo_r;
    end
    if (hb > hi_r) su_done = 1'b1;
    else if (he > hi_r) he = hi_r;
    su_ent.head_lo = hb;
    su_ent.head_hi = he;
    su_ent.tail_lo = tb;
    su_ent.tail_hi = te;
    su_ent.cursor  = tback_r ? te : hb;
  end

  // ---------------- node selection ----------------
  logic [MAX_NODES-1:0] act;
  logic [NCW-1:0]       act_cnt;
  logic [NW-1:0]        only_idx;
  logic                 pick_hit;
  logic [NW-1:0]        pick_idx;

  always_comb begin
    logic own_act;
    logic found;
    own_act  = 1'b0;
    found    = 1'b0;
    act_cnt  = '0;
    only_idx = '0;
    pick_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      act[i] = (i < int'(n_r)) && !done_r[slot_addr(t_r, NW'(i))];
    end
    for (int i = 0; i < MAX_NODES; i++) begin
      act_cnt = act_cnt + NCW'(act[i]);
      if (act[i]) only_idx = NW'(i);
      if (act[i] && i == int'(req_own_r)) own_act = 1'b1;
      if (!found && act[i] && i != int'(req_own_r)) begin
        found    = 1'b1;
        pick_idx = NW'(i);
      end
    end
    if (own_act) pick_idx = NW'(req_own_r);
    pick_hit = own_act || found;
  end

  // ---------------- take one unit ----------------
  val_t tk_st, tk_en, tk_cur, fin_st, fin_en;
  logic tk_done;

  always_comb begin
    val_t p, sb;
    p       = ent_r.cursor;
    sb      = val_t'(b_r / SMALL_DIV);
    if (sb < 1) sb = val_t'(1);
    tk_done = 1'b0;
    tk_st   = p;
    tk_cur  = p;
    if (!tback_r) begin
      if (p == ent_r.head_lo) begin
        tk_en  = ent_r.head_hi;
        tk_cur = ent_r.head_hi + cx - bx + 1;
      end else if (p >= ent_r.tail_lo) begin
        if (last_r) begin
          tk_en = p + sb - 1;
          if (tk_en > ent_r.tail_hi) tk_en = ent_r.tail_hi;
          tk_cur = p + sb;
        end else begin
          tk_en   = ent_r.tail_hi;
          tk_done = 1'b1;
        end
      end else begin
        tk_en  = p + bx - 1;
        tk_cur = p + cx;
      end
      if (tk_cur > ent_r.tail_hi) tk_done = 1'b1;
    end else begin
      if (p == ent_r.head_hi) begin
        tk_en   = ent_r.head_lo;
        tk_done = 1'b1;
      end else if (p == ent_r.tail_hi) begin
        tk_en  = ent_r.tail_lo;
        tk_cur = ent_r.tail_lo - cx + bx - 1;
      end else begin
        tk_en  = p - bx + 1;
        tk_cur = p - cx;
      end
      if (tk_cur < ent_r.head_lo) tk_done = 1'b1;
    end
    // clamp to the requester's page count
    fin_st = (req_back_r && tk_st >= pcx) ? pcx - 1 : tk_st;
    fin_en = (!req_back_r && tk_en >= pcx) ? pcx - 1 : tk_en;
  end

  // ---------------- node RAM ----------------
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr, cur_addr;
  node_ent_t       ram_wdata, ram_rdata;
  logic [EW-1:0]   ram_rbits;

  assign cur_addr = slot_addr(t_r, s_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = ent_r;
    ram_raddr = cur_addr;
    if (state_r == S_SETUP) begin
      ram_we    = 1'b1;
      ram_waddr = slot_addr(t_r, i_r);
      ram_wdata = su_ent;
    end else if (state_r == S_TAKE) begin
      ram_we           = 1'b1;
      ram_wdata.cursor = tk_cur;
    end
    if (state_r == S_PICK) ram_raddr = slot_addr(t_r, pick_idx);
  end

  prwd_ram #(
    .WIDTH (EW),
    .DEPTH (NSLOT),
    .ADDR_W(AW)
  ) u_node_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rbits)
  );
  assign ram_rdata = node_ent_t'(ram_rbits);

  // backward skip: is a multi-unit jump worth computing
  val_t sk_low;
  logic sk_cond;
  assign sk_low  = ram_rdata.cursor - bx + 1;
  assign sk_cond = (ram_rdata.cursor != ram_rdata.head_hi) &&
                   (ram_rdata.cursor != ram_rdata.tail_hi) &&
                   (sk_low >= pcx) && (ram_rdata.cursor > ram_rdata.head_hi);

  // ---------------- remainder unit ----------------
  logic          div_start, div_done;
  logic [VW-1:0] div_dvd;
  logic [CW-1:0] div_rem;
  val_t          jm;

  assign div_start = (state_r == S_DGO);

  always_comb begin
    val_t j1, j2;
    case (div_sel_r)
      DIV_LO:  div_dvd = VW'(lo_r);
      DIV_HI:  div_dvd = VW'((hi_r < 0) ? -hi_r : hi_r);
      DIV_SK1: div_dvd = VW'(d1_r);
      default: div_dvd = VW'(d2_r);
    endcase
    j1 = d1_r - val_t'(ra_r);
    j2 = d2_r - val_t'(div_rem) - cx;
    jm = (j1 < j2) ? j1 : j2;
  end

  prwd_rem u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (c_r),
    .done    (div_done),
    .rem     (div_rem)
  );

  // ---------------- handshakes ----------------
  logic out_free;
  assign in_stall        = !rst_n || (state_r != S_IDLE);
  assign cfg_ready       = rst_n;
  assign out_free        = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_first_block = out_st_r;
  assign out_last_block  = out_en_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NCFGW'(1);
      unit_size_r  <= UW'(512);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NODE_COUNT: node_count_r <= cfg_data[NCFGW-1:0];
        CFG_UNIT_SIZE:  unit_size_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r  <= 1'b1;
      out_status_r <= res_status_r;
      out_st_r     <= res_st_r;
      out_en_r     <= res_en_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_valid_r <= '0;
      skip_r       <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_op_r    <= in_operation;
            req_key_r   <= in_task_id;
            req_round_r <= in_scan_round;
            req_back_r  <= in_backward;
            req_whole_r <= in_whole_relation;
            req_ss_r    <= in_scan_start;
            req_cnt_r   <= in_scan_count;
            req_pc_r    <= in_page_count;
            req_own_r   <= in_node_index;
            state_r     <= S_LOOK;
          end
        end
        S_LOOK: begin
          skip_r   <= 1'b0;
          res_st_r <= '0;
          res_en_r <= '0;
          if (req_op_r) begin
            slot_valid_r <= '0;
            res_status_r <= ST_EMPTY;
            state_r      <= S_FIN;
          end else if (node_count_r == '0) begin
            res_status_r <= ST_EMPTY;
            state_r      <= S_FIN;
          end else if (match_hit) begin
            t_r     <= match_idx;
            tback_r <= slot_back_r[match_idx];
            lo_r    <= slot_lo_r[match_idx];
            hi_r    <= slot_hi_r[match_idx];
            n_r     <= slot_nodes_r[match_idx];
            if (slot_round_r[match_idx] > req_round_r) begin
              res_status_r <= ST_ROUND_DONE;
              state_r      <= S_FIN;
            end else if (slot_round_r[match_idx] < req_round_r) begin
              // newer round: restart all nodes with the current unit size
              slot_round_r[match_idx] <= slot_round_r[match_idx] + 32'd1;
              slot_unit_r[match_idx]  <= b_cur;
              b_r     <= b_cur;
              setup_r <= 1'b1;
              state_r <= S_PREP;
            end else begin
              b_r     <= slot_unit_r[match_idx];
              setup_r <= 1'b0;
              state_r <= S_PREP;
            end
          end else if (free_hit) begin
            slot_valid_r[free_idx] <= 1'b1;
            slot_key_r[free_idx]   <= req_key_r;
            slot_round_r[free_idx] <= req_round_r;
            slot_back_r[free_idx]  <= req_back_r;
            slot_lo_r[free_idx]    <= nlo;
            slot_hi_r[free_idx]    <= nhi;
            slot_nodes_r[free_idx] <= n_cur;
            slot_unit_r[free_idx]  <= b_cur;
            t_r     <= free_idx;
            tback_r <= req_back_r;
            lo_r    <= nlo;
            hi_r    <= nhi;
            n_r     <= n_cur;
            b_r     <= b_cur;
            setup_r <= 1'b1;
            state_r <= S_PREP;
          end else begin
            res_status_r <= ST_FULL;
            state_r      <= S_FIN;
          end
        end
        S_PREP: begin
          c_r <= CW'(b_r) * CW'(n_r);
          if (setup_r) begin
            div_sel_r <= DIV_LO;
            state_r   <= S_DGO;
          end else begin
            state_r <= S_PICK;
          end
        end
        S_DGO: begin
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            case (div_sel_r)
              DIV_LO: begin
                ra_r      <= div_rem;
                div_sel_r <= DIV_HI;
                state_r   <= S_DGO;
              end
              DIV_HI: begin
                // aligned round starts of the first and last unit rows
                hp_r    <= lo_r - val_t'(ra_r);
                tp_r    <= (hi_r < 0) ? hi_r + val_t'(div_rem) : hi_r - val_t'(div_rem);
                i_r     <= '0;
                bi_r    <= '0;
                state_r <= S_SETUP;
              end
              DIV_SK1: begin
                ra_r      <= div_rem;
                div_sel_r <= DIV_SK2;
                state_r   <= S_DGO;
              end
              default: begin
                if (jm >= cx) ent_r.cursor <= ent_r.cursor - jm;
                state_r <= S_TAKE;
              end
            endcase
          end
        end
        S_SETUP: begin
          done_r[slot_addr(t_r, i_r)] <= su_done;
          i_r  <= i_r + 1'b1;
          bi_r <= bi_r + bx;
          if (NCW'(i_r) + NCW'(1) == n_r) state_r <= S_PICK;
        end
        S_PICK: begin
          if (!pick_hit) begin
            res_status_r <= ST_EMPTY;
            res_st_r     <= '0;
            res_en_r     <= '0;
            state_r      <= S_FIN;
          end else begin
            s_r     <= pick_idx;
            last_r  <= (act_cnt == NCW'(1)) && (only_idx == pick_idx);
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          ent_r   <= ram_rdata;
          state_r <= S_TAKE;
        end
        S_TAKE: begin
          done_r[cur_addr] <= tk_done ||
                              (!skip_r && req_back_r && tk_en >= pcx && !tback_r);
          if (skip_r || req_back_r) begin
            if (tk_en < pcx) begin
              res_status_r <= ST_GRANT;
              res_st_r     <= fin_st[PW-1:0];
              res_en_r     <= fin_en[PW-1:0];
              state_r      <= S_FIN;
            end else if (skip_r || tback_r) begin
              skip_r  <= 1'b1;
              state_r <= S_SKRD;
            end else begin
              state_r <= S_PICK;
            end
          end else if (tk_st >= pcx) begin
            res_status_r <= ST_BEYOND;
            res_st_r     <= '0;
            res_en_r     <= '0;
            state_r      <= S_FIN;
          end else begin
            res_status_r <= ST_GRANT;
            res_st_r     <= fin_st[PW-1:0];
            res_en_r     <= fin_en[PW-1:0];
            state_r      <= S_FIN;
          end
        end
        S_SKRD: begin
          if (done_r[cur_addr]) begin
            skip_r  <= 1'b0;
            state_r <= S_PICK;
          end else begin
            state_r <= S_SKLD;
          end
        end
        S_SKLD: begin
          ent_r  <= ram_rdata;
          last_r <= 1'b0;
          d1_r   <= sk_low - pcx;
          d2_r   <= ram_rdata.cursor - ram_rdata.head_hi;
          if (sk_cond) begin
            div_sel_r <= DIV_SK1;
            state_r   <= S_DGO;
          end else begin
            state_r <= S_TAKE;
          end
        end
        S_FIN: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  `PRWD_ASSERT_SAME(a_take_live_node, clk, rst_n, state_r == S_TAKE, !done_r[cur_addr], "unit taken from a finished node")
  `PRWD_ASSERT_SAME(a_div_done_in_wait, clk, rst_n, div_done, state_r == S_DWAIT, "remainder finished outside wait state")
  `PRWD_ASSERT_SAME(a_refusal_zero, clk, rst_n, state_r == S_FIN && res_status_r != ST_GRANT, res_st_r == '0 && res_en_r == '0, "refused transaction carries a range")
  `PRWD_ASSERT_NEXT(a_fin_delivers, clk, rst_n, state_r == S_FIN && out_free, out_valid_r && state_r == S_IDLE, "finished result not presented")
endmodule
